### design/fbd_pkg.sv
package fbd_pkg;

   localparam int PIXEL_W = 8;

   // Nine 8-bit terms sum to at most 2295.
   localparam int SUM_W = 12;

   // Reciprocal constants for the two divisors. They are exact over the full
   // sum range: below 32768 for nine and below 2048 for six.
   localparam int RECIP_W = 12;
   localparam int SHIFT9 = 15;
   localparam int SHIFT6 = 13;
   localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(((1 << SHIFT9) + 8) / 9);
   localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(((1 << SHIFT6) + 5) / 6);
   localparam int PROD_W = SUM_W + RECIP_W;

   localparam logic [PIXEL_W-1:0] FLOOR_RESET = 8'd10;

   // Neighborhood of one pixel, as seen by the filter kernel.
   typedef struct packed {
      logic [PIXEL_W-1:0] center;
      logic [PIXEL_W-1:0] left;
      logic [PIXEL_W-1:0] right;
      logic [PIXEL_W-1:0] above_left;
      logic [PIXEL_W-1:0] above;
      logic [PIXEL_W-1:0] above_right;
      logic [PIXEL_W-1:0] below_left;
      logic [PIXEL_W-1:0] below;
      logic [PIXEL_W-1:0] below_right;
      logic               row_begin;
      logic               row_finish;
   } window_type;

endpackage

### design/fbd_row_store.sv
module fbd_row_store #(
   parameter int ROW_WIDTH = 320,
   parameter int ADDR_W = $clog2(ROW_WIDTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr0,
   input  logic [ADDR_W-1:0] rd_addr1,
   output logic [7:0]        rd_data0,
   output logic [7:0]        rd_data1,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] mem [ROW_WIDTH];
   logic [7:0] rd_data0_ff;
   logic [7:0] rd_data1_ff;

   // Read returns the entry as it was before a write at the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data0_ff <= mem[rd_addr0];
         rd_data1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

### design/fbd_kernel.sv
module fbd_kernel (
   input  fbd_pkg::window_type win,
   input  logic [7:0]          floor_level,
   output logic [7:0]          pixel
);

   import fbd_pkg::*;

   logic [SUM_W-1:0]   sum;
   logic [PROD_W-1:0]  prod9;
   logic [PROD_W-1:0]  prod6;
   logic [PIXEL_W-1:0] avg;

   always_comb begin
      if (win.row_begin) begin
         sum = SUM_W'(win.center) + SUM_W'(win.above) + SUM_W'(win.above_right)
             + SUM_W'(win.right) + SUM_W'(win.below_right) + SUM_W'(win.below);
      end else if (win.row_finish) begin
         sum = SUM_W'(win.center) + SUM_W'(win.above) + SUM_W'(win.above_left)
             + SUM_W'(win.left) + SUM_W'(win.below_left) + SUM_W'(win.below);
      end else begin
         sum = SUM_W'(win.center) + SUM_W'(win.left) + SUM_W'(win.right)
             + SUM_W'(win.above_left) + SUM_W'(win.above) + SUM_W'(win.above_right)
             + SUM_W'(win.below_left) + SUM_W'(win.below) + SUM_W'(win.below_right);
      end
   end

   // Divide by a constant through a reciprocal multiply.
   assign prod9 = PROD_W'(sum) * PROD_W'(RECIP9);
   assign prod6 = PROD_W'(sum) * PROD_W'(RECIP6);

   always_comb begin
      if (win.row_begin || win.row_finish) begin
         avg = prod6[SHIFT6+PIXEL_W-1:SHIFT6];
      end else begin
         avg = prod9[SHIFT9+PIXEL_W-1:SHIFT9];
      end
   end

   // Decay by one, never below the floor.
   assign pixel = (avg > floor_level) ? avg - 8'd1 : floor_level;

endmodule

### design/fire_effect_blur_decay.sv
// An accepted request is registered in the compute stage; its result is then registered for rsp_.
// Throughput: one pixel per clock while rsp_stall is low; the left-neighbor loop
//    closes combinationally through the kernel; the store can read and write at once.
// Reset (synchronous, active high): pipeline empties, left and held pixels and
//    the column counter clear, floor_level returns to 10. The row store is not
//    cleared; its contents are undefined until the first row writes them.
module fire_effect_blur_decay #(
   parameter int ROW_WIDTH = 320
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_raw_center,
   input  logic [7:0] req_raw_right,
   input  logic [7:0] req_raw_below_left,
   input  logic [7:0] req_raw_below,
   input  logic [7:0] req_raw_below_right,
   input  logic [7:0] req_context_above_left,
   input  logic [7:0] req_context_above,
   input  logic [7:0] req_context_above_right,
   input  logic       req_row_begin,
   input  logic       req_row_finish,
   input  logic       req_first_row,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_flame_pixel,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   import fbd_pkg::*;

   localparam int COL_W = $clog2(ROW_WIDTH);
   localparam logic [COL_W:0]   ROW_END  = (COL_W+1)'(ROW_WIDTH);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_WIDTH - 1);

   // Request held in the compute stage, with its column and forwarding marks.
   typedef struct packed {
      logic [PIXEL_W-1:0] raw_center;
      logic [PIXEL_W-1:0] raw_right;
      logic [PIXEL_W-1:0] raw_below_left;
      logic [PIXEL_W-1:0] raw_below;
      logic [PIXEL_W-1:0] raw_below_right;
      logic [PIXEL_W-1:0] context_above_left;
      logic [PIXEL_W-1:0] context_above;
      logic [PIXEL_W-1:0] context_above_right;
      logic               row_begin;
      logic               row_finish;
      logic               first_row;
      logic [COL_W-1:0]   col;
      logic               fwd_up;      // store entry at col was being written on read
      logic               fwd_up_right;
      logic               past_end;    // above-right lies beyond the store
   } stage_type;

   stage_type          stage_ff, stage_in;
   logic               stage_valid_ff, stage_valid_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [PIXEL_W-1:0] left_ff, left_in;
   logic [PIXEL_W-1:0] held_ff, held_in;
   logic [PIXEL_W-1:0] floor_ff, floor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;

   logic               req_accept;
   logic               stage_move;
   logic [COL_W-1:0]   req_col;
   logic [COL_W:0]     req_col_next;
   logic               req_past_end;
   logic [COL_W-1:0]   rd_addr_right;
   logic [PIXEL_W-1:0] rd_up;
   logic [PIXEL_W-1:0] rd_up_right;
   logic [PIXEL_W-1:0] old_up;
   logic [PIXEL_W-1:0] old_up_right;
   window_type         win;
   logic [PIXEL_W-1:0] result;

   // Handshake: advance the compute stage whenever the result register frees.
   assign stage_move = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !stage_move;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Column of the incoming request; the counter runs at accept time since it
   // depends only on the row marks, never on results.
   assign req_col      = req_row_begin ? '0 : col_ff;
   assign req_col_next = {1'b0, req_col} + (COL_W+1)'(1);
   assign req_past_end = (req_col_next == ROW_END);
   assign rd_addr_right = req_past_end ? req_col : req_col_next[COL_W-1:0];

   fbd_row_store #(
      .ROW_WIDTH (ROW_WIDTH),
      .ADDR_W    (COL_W)
   ) u_store (
      .clock    (clock),
      .rd_en    (req_accept),
      .rd_addr0 (req_col),
      .rd_addr1 (rd_addr_right),
      .rd_data0 (rd_up),
      .rd_data1 (rd_up_right),
      .wr_en    (stage_move),
      .wr_addr  (stage_ff.col),
      .wr_data  (result)
   );

   // The store read misses a write landing at the same edge. That write is
   // always the previous request's result, which is exactly left_ff now.
   assign old_up = stage_ff.fwd_up ? left_ff : rd_up;

   always_comb begin
      if (stage_ff.past_end) begin
         old_up_right = '0;
      end else if (stage_ff.fwd_up_right) begin
         old_up_right = left_ff;
      end else begin
         old_up_right = rd_up_right;
      end
   end

   // Assemble the neighborhood: the upper row from context on the first row.
   always_comb begin
      win.center      = stage_ff.raw_center;
      win.left        = left_ff;
      win.right       = stage_ff.raw_right;
      win.below_left  = stage_ff.raw_below_left;
      win.below       = stage_ff.raw_below;
      win.below_right = stage_ff.raw_below_right;
      win.row_begin   = stage_ff.row_begin;
      win.row_finish  = stage_ff.row_finish;
      if (stage_ff.first_row) begin
         win.above_left  = stage_ff.context_above_left;
         win.above       = stage_ff.context_above;
         win.above_right = stage_ff.context_above_right;
      end else begin
         win.above_left  = held_ff;
         win.above       = old_up;
         win.above_right = old_up_right;
      end
   end

   fbd_kernel u_kernel (
      .win         (win),
      .floor_level (floor_ff),
      .pixel       (result)
   );

   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      col_in         = col_ff;
      left_in        = left_ff;
      held_in        = held_ff;
      floor_in       = floor_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pixel_in   = rsp_pixel_ff;

      if (csr_valid) begin
         floor_in = csr_data;
      end

      // Drop the result once taken; a moving stage refills it at once.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (stage_move) begin
         rsp_valid_in   = 1'b1;
         rsp_pixel_in   = result;
         left_in        = result;
         held_in        = old_up;
         stage_valid_in = 1'b0;
      end

      if (req_accept) begin
         stage_valid_in                = 1'b1;
         stage_in.raw_center           = req_raw_center;
         stage_in.raw_right            = req_raw_right;
         stage_in.raw_below_left       = req_raw_below_left;
         stage_in.raw_below            = req_raw_below;
         stage_in.raw_below_right      = req_raw_below_right;
         stage_in.context_above_left   = req_context_above_left;
         stage_in.context_above        = req_context_above;
         stage_in.context_above_right  = req_context_above_right;
         stage_in.row_begin            = req_row_begin;
         stage_in.row_finish           = req_row_finish;
         stage_in.first_row            = req_first_row;
         stage_in.col                  = req_col;
         stage_in.fwd_up               = stage_move && (stage_ff.col == req_col);
         stage_in.fwd_up_right         = stage_move && !req_past_end
                                         && (stage_ff.col == rd_addr_right);
         stage_in.past_end             = req_past_end;
         // Hold at the last column when a row runs long.
         col_in = req_past_end ? LAST_COL : req_col_next[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         col_ff         <= '0;
         left_ff        <= '0;
         held_ff        <= '0;
         floor_ff       <= FLOOR_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         col_ff         <= col_in;
         left_ff        <= left_in;
         held_ff        <= held_in;
         floor_ff       <= floor_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      stage_ff     <= stage_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_flame_pixel = rsp_pixel_ff;

endmodule
